>>> hw/rtl/lcps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcps_pkg
// Shared types and constants for the LED cube plane scan serializer.
// ----------------------------------------------------------------------------
package lcps_pkg;

  // Width of one color level on the input stream.
  localparam int LEVEL_BITS       = 12;
  // Widest channel the store supports; levels are zero-extended to this first.
  localparam int CHAN_BITS_MAX    = 16;
  localparam int LEVEL_PAD        = CHAN_BITS_MAX - LEVEL_BITS;

  localparam int COORD_BITS       = 2;
  localparam int PIXEL_COUNT      = 64;
  localparam int PIXEL_ADDR_BITS  = 3 * COORD_BITS;
  localparam int WORDS_PER_SCAN   = 16;
  localparam int WORD_CNT_BITS    = 4;

  localparam int IN_TDATA_BITS    = 48;

  // Serpentine reset position.
  localparam logic [COORD_BITS-1:0] SCAN_X_RESET = 2'd0;
  localparam logic [COORD_BITS-1:0] SCAN_Y_RESET = 2'd1;
  localparam logic [COORD_BITS-1:0] COORD_MAX    = 2'd3;
  localparam logic [COORD_BITS-1:0] COORD_MIN    = 2'd0;

  localparam logic [WORD_CNT_BITS-1:0] LAST_WORD_IDX = 4'd15;

  // Command carried on s_tuser.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SCAN  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

>>> hw/rtl/lcps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lcps_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/led_cube_plane_scan_serializer.sv
`timescale 1ns / 1ps
// A write transfer is stored at its accept edge; writes are taken back to back
// while idle. A scan's words pass through the registered store read and then
// the output queue, one word per cycle while m_tready is high; the sequencer
// issues one pixel-store read per cycle while the output queue has room; a scan
// holds s_tready low until its sixteenth read issues, longer if output stalls.
// Reset (rst, synchronous): per-entry valid bits clear, so the store reads as
// zero at once with no clearing pass; scan position goes to x=0, y=1, plane 0.
// ----------------------------------------------------------------------------
// led_cube_plane_scan_serializer
// Holds a 4x4x4 RGB pixel store and serializes one plane per scan command in
// serpentine order as 16 words for the SPI frame.
// ----------------------------------------------------------------------------
module led_cube_plane_scan_serializer
  import lcps_pkg::*;
#(
  parameter int CHANNEL_BITS = 12,
  localparam int WORD_BITS   = 3 * CHANNEL_BITS,
  localparam int OUT_BITS    = ((WORD_BITS + COORD_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // s_tdata, low bit up: pix_x[2], pix_y[2], pix_z[2], red_level[12],
  // green_level[12], blue_level[12], zero pad[6]
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_TDATA_BITS-1:0] s_tdata,
  input  logic                     s_tuser,   // cmd
  // m_tdata, low bit up: led_word[WORD_BITS], plane_enable[2], zero pad
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_BITS-1:0]      m_tdata,
  output logic                     m_tlast    // last_word
);

  localparam int ENTRY_BITS = WORD_BITS + COORD_BITS + 1;

  // ---------------- input decode ----------------
  logic [COORD_BITS-1:0]    in_x, in_y, in_z;
  logic [LEVEL_BITS-1:0]    in_red, in_green, in_blue;
  logic [CHAN_BITS_MAX-1:0] red_ext, green_ext, blue_ext;
  logic [WORD_BITS-1:0]     wr_word;
  logic                     in_xfer, wr_en, scan_start;

  assign in_x     = s_tdata[1:0];
  assign in_y     = s_tdata[3:2];
  assign in_z     = s_tdata[5:4];
  assign in_red   = s_tdata[17:6];
  assign in_green = s_tdata[29:18];
  assign in_blue  = s_tdata[41:30];

  assign red_ext   = {{LEVEL_PAD{1'b0}}, in_red};
  assign green_ext = {{LEVEL_PAD{1'b0}}, in_green};
  assign blue_ext  = {{LEVEL_PAD{1'b0}}, in_blue};
  assign wr_word   = {blue_ext[CHANNEL_BITS-1:0], green_ext[CHANNEL_BITS-1:0],
                      red_ext[CHANNEL_BITS-1:0]};

  assign in_xfer    = s_tvalid && s_tready;
  assign wr_en      = in_xfer && (cmd_t'(s_tuser) == CMD_WRITE);
  assign scan_start = in_xfer && (cmd_t'(s_tuser) == CMD_SCAN);

  // ---------------- scan sequencer ----------------
  state_t                   state, state_next;
  logic [COORD_BITS-1:0]    scan_x, scan_y, scan_plane;
  logic [COORD_BITS-1:0]    scan_x_next, scan_y_next;
  logic [WORD_CNT_BITS-1:0] word_cnt;
  logic                     rd_issue, rd_last;
  logic [PIXEL_ADDR_BITS-1:0] rd_addr;

  // output queue bookkeeping
  logic [1:0] q_count;
  logic       rd_pending;
  logic       pop;
  logic [2:0] slots_used;

  assign s_tready = (state == ST_IDLE);

  assign pop        = m_tvalid && m_tready;
  assign slots_used = 3'(q_count) + 3'(rd_pending) - 3'(pop);
  assign rd_issue   = (state == ST_SCAN) && (slots_used < 3'd2);
  assign rd_last    = (word_cnt == LAST_WORD_IDX);
  assign rd_addr    = {scan_x, scan_y, scan_plane};

  // serpentine step: odd rows run x up, even rows run x down
  always_comb begin
    scan_x_next = scan_x;
    scan_y_next = scan_y;
    case (scan_y)
      2'd0: begin
        if (scan_x == COORD_MIN) scan_y_next = 2'd3;
        else                     scan_x_next = scan_x - 2'd1;
      end
      2'd1: begin
        if (scan_x == COORD_MAX) scan_y_next = 2'd0;
        else                     scan_x_next = scan_x + 2'd1;
      end
      2'd2: begin
        if (scan_x == COORD_MIN) scan_y_next = 2'd1;
        else                     scan_x_next = scan_x - 2'd1;
      end
      default: begin
        if (scan_x == COORD_MAX) scan_y_next = 2'd2;
        else                     scan_x_next = scan_x + 2'd1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (scan_start) state_next = ST_SCAN;
      ST_SCAN: if (rd_issue && rd_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_x     <= SCAN_X_RESET;
      scan_y     <= SCAN_Y_RESET;
      scan_plane <= '0;
      word_cnt   <= '0;
    end else begin
      state <= state_next;
      if (scan_start) begin
        word_cnt <= '0;
      end else if (rd_issue) begin
        word_cnt <= word_cnt + 1'b1;
        scan_x   <= scan_x_next;
        scan_y   <= scan_y_next;
        if (rd_last) scan_plane <= scan_plane + 1'b1;
      end
    end
  end

  // ---------------- pixel store ----------------
  logic [PIXEL_COUNT-1:0] pix_valid;
  logic [WORD_BITS-1:0]   ram_rdata;
  logic                   rd_valid;
  logic                   rd_last_q;
  logic [COORD_BITS-1:0]  rd_plane_q;

  lcps_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (PIXEL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr ({in_x, in_y, in_z}),
    .wdata (wr_word),
    .re    (rd_issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid  <= '0;
      rd_pending <= 1'b0;
    end else begin
      if (wr_en) pix_valid[{in_x, in_y, in_z}] <= 1'b1;
      rd_pending <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_valid   <= pix_valid[rd_addr];
      rd_last_q  <= rd_last;
      rd_plane_q <= rd_last ? scan_plane : '0;
    end
  end

  // ---------------- two-entry output queue ----------------
  logic [ENTRY_BITS-1:0] q_mem [2];
  logic                  q_head, q_tail;
  logic [ENTRY_BITS-1:0] push_entry, head_entry;
  logic [WORD_BITS-1:0]  push_word;

  assign push_word  = rd_valid ? ram_rdata : '0;
  assign push_entry = {rd_last_q, rd_plane_q, push_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
      q_head  <= 1'b0;
      q_tail  <= 1'b0;
    end else begin
      if (rd_pending) q_tail <= ~q_tail;
      if (pop)        q_head <= ~q_head;
      q_count <= 2'(3'(q_count) + 3'(rd_pending) - 3'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) q_mem[q_tail] <= push_entry;
  end

  assign head_entry = q_mem[q_head];
  assign m_tvalid   = (q_count != 2'd0);
  assign m_tlast    = head_entry[ENTRY_BITS-1];
  assign m_tdata    = OUT_BITS'(head_entry[ENTRY_BITS-2:0]);

endmodule
